/* rtl/core/mzsf_pkg.sv */
// Shared types and constants for the moving-zero state-feedback controller.
package mzsf_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN_POSITION  = 3'd0;
  localparam logic [2:0] REG_GAIN_VELOCITY  = 3'd1;
  localparam logic [2:0] REG_GAIN_INTEGRAL  = 3'd2;
  localparam logic [2:0] REG_GAIN_POSE      = 3'd3;
  localparam logic [2:0] REG_GAIN_ACCEL     = 3'd4;
  localparam logic [2:0] REG_RATE_LIMIT     = 3'd5;
  localparam logic [2:0] REG_POSE_LIMIT     = 3'd6;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd7;

  localparam logic signed [63:0] ONE_Q16     = 64'sd65536;
  localparam logic signed [63:0] ACC_CLAMP   = 64'sd131072000;
  localparam logic signed [63:0] POSE_MARGIN = 64'sd327680;
  localparam logic [31:0]        GAP_MIN_MS  = 32'd10;
  localparam logic [31:0]        GAP_MAX_MS  = 32'd100;

  // Multiply-divide unit request: product of two operands, rounded divide
  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic        [31:0] d;
  } md_req_t;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } md_state_t;

  function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
      input logic signed [63:0] lo, input logic signed [63:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    return clampv(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

endpackage

/* rtl/core/mzsf_muldiv.sv */
// Bit-serial signed multiply then round-to-nearest divide by an unsigned divisor.
module mzsf_muldiv
  import mzsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  md_req_t            req,
  output logic               done,
  output logic signed [63:0] result
);

  md_state_t          state;
  logic        [63:0] mcand;
  logic        [63:0] mplier;
  logic        [63:0] prod;
  logic        [63:0] rem;
  logic        [63:0] quo;
  logic        [31:0] dvs;
  logic               neg;
  logic        [6:0]  cnt;
  logic        [64:0] trial;
  logic        [63:0] num;

  assign trial = {rem[63:0], num[63]} - {33'd0, dvs};

  // one multiplier bit, then one quotient bit, per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_LOAD;
        end
        S_LOAD: begin
          neg    <= req.a[63] ^ req.b[63];
          mcand  <= req.a[63] ? -req.a : req.a;
          mplier <= req.b[63] ? -req.b : req.b;
          dvs    <= req.d;
          prod   <= '0;
          cnt    <= '0;
          state  <= S_MUL;
        end
        S_MUL: begin
          if (mplier[0]) prod <= prod + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= (cnt == 7'd63) ? 7'd0 : cnt + 7'd1;
          if (cnt == 7'd63) state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 7'd0) begin
            // rounding: add half the divisor first
            num <= prod + {33'd0, dvs[31:1]};
            rem <= '0;
            quo <= '0;
            cnt <= 7'd1;
          end else begin
            if (!trial[64]) begin
              rem <= trial[63:0];
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= {rem[62:0], num[63]};
              quo <= {quo[62:0], 1'b0};
            end
            num <= num << 1;
            cnt <= cnt + 7'd1;
            if (cnt == 7'd64) state <= S_DONE;
          end
        end
        S_DONE: begin
          result <= neg ? -$signed(quo) : $signed(quo);
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/moving_zero_state_feedback.sv */
// Top level of the moving-zero state-feedback controller.
//
//  channel | dir | handshake               | content
//  s_axis  | in  | s_axis_tvalid/tready    | one control tick
//  m_axis  | out | m_axis_tvalid/tready    | one result per tick
//  cfg     | in  | cfg_we                  | register writes, no read-back
//
// A tick runs up to 13 rounded multiply/divide steps in sequence on one
// bit-serial unit, each going through start, load, multiply, divide, done
// and hand-off; a tick whose last frame is missing or older than HOLD_MS
// skips the integral and the feedback terms but the acceleration term.
// A clear goes straight to the output step. Reset is synchronous, clears the
// controller state and the registers. The result sits in an output register,
// so a new tick is taken while it waits; a stalled output holds the last step.
module moving_zero_state_feedback
  import mzsf_pkg::*;
#(
  parameter int VEL_ALPHA_Q16   = 16384,
  parameter int ACCEL_ALPHA_Q16 = 16384,
  parameter int HOLD_MS         = 100,
  parameter int LEAK_PER_S_Q16  = 65536
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [0] cmd, [1] new_frame, [33:2] ball_pos, [65:34] ball_speed,
  // [97:66] frame_time_ms, [129:98] now_ms, [139:130] tick_ms,
  // [156:140] applied_rate, zero filled
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] rate_out, [32] valid_res, [64:33] integral_term,
  // [96:65] accel_estimate, [128:97] accel_term, [160:129] pose_out
  output logic [167:0] m_axis_tdata
);

  localparam logic [31:0] D_Q16  = 32'd65536;
  localparam logic [31:0] D_MS   = 32'd1000;
  localparam logic [31:0] D_ONE  = 32'd1;

  // step codes of the tick sequencer, one-hot
  typedef enum logic [15:0] {
    P_IDLE    = 16'h0001,
    P_POSE    = 16'h0002,
    P_ACC_RAW = 16'h0004,
    P_ACC_FLT = 16'h0008,
    P_VEL     = 16'h0010,
    P_FRAME   = 16'h0020,
    P_PRED    = 16'h0040,
    P_INTEG   = 16'h0080,
    P_LEAK    = 16'h0100,
    P_LEAKMUL = 16'h0200,
    P_T0      = 16'h0400,
    P_T1      = 16'h0800,
    P_T2      = 16'h1000,
    P_T3      = 16'h2000,
    P_T4      = 16'h4000,
    P_OUT     = 16'h8000
  } phase_t;

  // configuration
  logic signed [63:0] g_pos, g_vel, g_int, g_pose, g_acc, r_lim, p_lim, i_lim;

  // state
  logic signed [63:0] vel_f, acc_f, last_pos, prev_spd, integ, pose;
  logic        [31:0] last_ft;
  logic               seen;

  // latched item
  logic               frame;
  logic signed [63:0] pos_in, spd_in, tick, applied;
  logic        [31:0] ftime, now_in;

  logic signed [63:0] pred, acc_w, sum, tmp;
  logic               valid_w;

  phase_t             ph;
  logic               busy, issued;
  md_req_t            req;
  logic               md_start, md_done;
  logic signed [63:0] md_res;
  logic               out_load;

  logic        [31:0] fdt, age;
  logic signed [63:0] bound, rate_w;

  assign fdt   = ftime - last_ft;
  assign age   = now_in - last_ft;
  assign bound = sat32(p_lim + POSE_MARGIN);

  mzsf_muldiv u_md (
    .clk(clk), .rst(rst), .start(md_start), .req(req),
    .done(md_done), .result(md_res)
  );

  assign s_axis_tready = !busy;

  // last step may load the output register once it is free
  assign out_load = busy && ph == P_OUT && (!m_axis_tvalid || m_axis_tready);

  // operand select for the current step
  always_comb begin
    req = '{a: 64'sd0, b: 64'sd0, d: D_ONE};
    unique case (ph)
      P_POSE:    req = '{a: applied * ONE_Q16, b: tick, d: D_MS};
      P_ACC_RAW: req = '{a: spd_in - prev_spd, b: 64'sd1000, d: fdt};
      P_ACC_FLT: req = '{a: 64'(ACCEL_ALPHA_Q16), b: tmp - acc_f, d: D_Q16};
      P_VEL:     req = '{a: 64'(VEL_ALPHA_Q16), b: spd_in - vel_f, d: D_Q16};
      P_PRED:    req = '{a: vel_f, b: {32'd0, age}, d: D_MS};
      P_INTEG:   req = '{a: pred, b: tick, d: D_MS};
      P_LEAK:    req = '{a: 64'(LEAK_PER_S_Q16), b: tick, d: D_MS};
      P_LEAKMUL: req = '{a: acc_w, b: tmp, d: D_Q16};
      P_T0:      req = '{a: g_pos, b: pred, d: D_Q16};
      P_T1:      req = '{a: g_vel, b: vel_f, d: D_Q16};
      P_T2:      req = '{a: g_int, b: integ, d: D_Q16};
      P_T3:      req = '{a: g_pose, b: pose, d: D_Q16};
      P_T4:      req = '{a: g_acc, b: acc_f, d: D_Q16};
      default:   req = '{a: 64'sd0, b: 64'sd0, d: D_ONE};
    endcase
  end

  assign md_start = busy && !issued && ph != P_FRAME && ph != P_OUT && ph != P_IDLE;

  always_comb begin
    rate_w = clampv(sum, -r_lim, r_lim);
    if ((pose >= p_lim && rate_w > 0) || (pose <= -p_lim && rate_w < 0)) rate_w = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_pos <= '0; g_vel <= '0; g_int <= '0; g_pose <= '0; g_acc <= '0;
      r_lim <= '0; p_lim <= '0; i_lim <= '0;
      vel_f <= '0; acc_f <= '0; last_pos <= '0; prev_spd <= '0; integ <= '0;
      pose <= '0; last_ft <= '0; seen <= 1'b0;
      busy <= 1'b0; issued <= 1'b0; ph <= P_IDLE; m_axis_tvalid <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_POSITION:  begin g_pos <= {33'd0, cfg_data[30:0]}; integ <= '0; end
          REG_GAIN_VELOCITY:  begin g_vel <= {33'd0, cfg_data[30:0]}; integ <= '0; end
          REG_GAIN_INTEGRAL:  begin g_int <= {33'd0, cfg_data[30:0]}; integ <= '0; end
          REG_GAIN_POSE:      begin g_pose <= {33'd0, cfg_data[30:0]}; integ <= '0; end
          REG_GAIN_ACCEL:     begin g_acc <= {{32{cfg_data[31]}}, cfg_data}; integ <= '0; end
          REG_RATE_LIMIT:     r_lim <= {33'd0, cfg_data[30:0]};
          REG_POSE_LIMIT:     p_lim <= {33'd0, cfg_data[30:0]};
          REG_INTEGRAL_LIMIT: i_lim <= {33'd0, cfg_data[30:0]};
          default: ;
        endcase
      end

      // output register: loads at the last step, drops once taken
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;

      // accept a tick
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tdata[0]) begin
          // clear: all-zero result goes straight to the output step
          vel_f <= '0; acc_f <= '0; last_pos <= '0; prev_spd <= '0; integ <= '0;
          pose <= '0; last_ft <= '0; seen <= 1'b0;
          pred    <= '0;
          valid_w <= 1'b0;
          busy    <= 1'b1;
          issued  <= 1'b0;
          ph      <= P_OUT;
        end else begin
          frame   <= s_axis_tdata[1];
          pos_in  <= {{32{s_axis_tdata[33]}}, s_axis_tdata[33:2]};
          spd_in  <= {{32{s_axis_tdata[65]}}, s_axis_tdata[65:34]};
          ftime   <= s_axis_tdata[97:66];
          now_in  <= s_axis_tdata[129:98];
          tick    <= {54'd0, s_axis_tdata[139:130]};
          applied <= {{47{s_axis_tdata[156]}}, s_axis_tdata[156:140]};
          busy    <= 1'b1;
          issued  <= 1'b0;
          ph      <= P_POSE;
        end
      end

      if (md_start) issued <= 1'b1;

      // step sequencer
      if (busy && (md_done || ph == P_FRAME || out_load)) begin
        issued <= 1'b0;
        unique case (ph)
          P_POSE: begin
            pose <= clampv(pose + md_res, -bound, bound);
            if (!frame) ph <= P_PRED;
            else if (!seen) begin
              vel_f <= spd_in; acc_f <= '0; ph <= P_FRAME;
            end else if (fdt >= GAP_MIN_MS && fdt <= GAP_MAX_MS) ph <= P_ACC_RAW;
            else begin
              acc_f <= '0; ph <= P_VEL;
            end
          end
          P_ACC_RAW: begin
            tmp <= clampv(md_res, -ACC_CLAMP, ACC_CLAMP);
            ph  <= P_ACC_FLT;
          end
          P_ACC_FLT: begin
            acc_f <= acc_f + md_res;
            ph    <= P_VEL;
          end
          P_VEL: begin
            vel_f <= vel_f + md_res;
            ph    <= P_FRAME;
          end
          P_FRAME: begin
            last_pos <= pos_in; prev_spd <= spd_in; last_ft <= ftime; seen <= 1'b1;
            ph <= P_PRED;
          end
          P_PRED: begin
            // stale or missing frame: only the acceleration term is still due
            if (!seen || age > 32'(HOLD_MS)) begin
              integ <= '0; valid_w <= 1'b0; ph <= P_T4;
            end else begin
              pred    <= sat32(last_pos + md_res);
              valid_w <= 1'b1;
              ph      <= P_INTEG;
            end
          end
          P_INTEG: begin
            acc_w <= integ + md_res;
            ph    <= P_LEAK;
          end
          P_LEAK: begin
            tmp <= clampv(ONE_Q16 - md_res, 64'sd0, ONE_Q16);
            ph  <= P_LEAKMUL;
          end
          P_LEAKMUL: begin
            integ <= clampv(md_res, -i_lim, i_lim);
            ph    <= P_T0;
          end
          P_T0: begin sum <= md_res; ph <= P_T1; end
          P_T1: begin sum <= sum + md_res; ph <= P_T2; end
          P_T2: begin
            sum <= sum + md_res; tmp <= sat32(md_res); ph <= P_T3;
          end
          P_T3: begin sum <= sum - md_res; ph <= P_T4; end
          P_T4: begin
            sum <= sum + md_res; pred <= sat32(md_res); ph <= P_OUT;
          end
          P_OUT: begin
            m_axis_tdata[31:0]    <= valid_w ? rate_w[31:0] : 32'd0;
            m_axis_tdata[32]      <= valid_w;
            m_axis_tdata[64:33]   <= valid_w ? tmp[31:0] : 32'd0;
            m_axis_tdata[96:65]   <= acc_f[31:0];
            m_axis_tdata[128:97]  <= pred[31:0];
            m_axis_tdata[160:129] <= pose[31:0];
            m_axis_tdata[167:161] <= '0;
            busy <= 1'b0;
            ph   <= P_IDLE;
          end
          default: ph <= P_IDLE;
        endcase
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking bench for the moving-zero state-feedback controller.
module tb_top
  import mzsf_pkg::*;
();

  localparam longint CYCLE_LIMIT = 64'd20000000;
  localparam int DRAIN_CYCLES = 2000;

  // Input beat, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic signed [16:0] applied;
    logic [9:0]         tick;
    logic [31:0]        now;
    logic [31:0]        ftime;
    logic signed [31:0] spd;
    logic signed [31:0] pos;
    logic               frame;
    logic               cmd;
  } tick_beat_t;

  // Output beat
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] pose;
    logic [31:0] aterm;
    logic [31:0] accel;
    logic [31:0] iterm;
    logic        valid;
    logic [31:0] rate;
  } ctrl_beat_t;

  // Controller predictor plus the queue of pending results
  class mzsf_scoreboard;
    longint g_pos, g_vel, g_int, g_pose, g_acc, lim_rate, lim_pose, lim_int;
    longint vel_f, acc_f, last_pos, prev_spd, integ, pose;
    logic [31:0] last_ft;
    bit seen;
    ctrl_beat_t pending[$];
    int errors;

    function new();
      g_pos = 0; g_vel = 0; g_int = 0; g_pose = 0; g_acc = 0;
      lim_rate = 0; lim_pose = 0; lim_int = 0; errors = 0;
      wipe();
    endfunction

    function void wipe();
      vel_f = 0; acc_f = 0; last_pos = 0; prev_spd = 0;
      integ = 0; pose = 0; last_ft = '0; seen = 0;
    endfunction

    // round to nearest, ties away from zero (d > 0)
    function longint rnd_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function longint lim(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint sat_q(longint v);
      return lim(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      longint u;
      u = longint'(v & 32'h7FFF_FFFF);
      case (idx)
        REG_GAIN_POSITION: begin g_pos = u; integ = 0; end
        REG_GAIN_VELOCITY: begin g_vel = u; integ = 0; end
        REG_GAIN_INTEGRAL: begin g_int = u; integ = 0; end
        REG_GAIN_POSE: begin g_pose = u; integ = 0; end
        REG_GAIN_ACCEL: begin g_acc = longint'($signed(v)); integ = 0; end
        REG_RATE_LIMIT: lim_rate = u;
        REG_POSE_LIMIT: lim_pose = u;
        REG_INTEGRAL_LIMIT: lim_int = u;
        default: ;
      endcase
    endfunction

    function void note_tick(tick_beat_t t);
      ctrl_beat_t r;
      longint p, s, tk, ap, bound, raw, fdt_l, age_l, pred, acc, leak, sum, rate, iterm;
      longint aterm_l;
      logic [31:0] fdt, age;
      bit valid;
      r = '0;
      p = t.pos; s = t.spd; tk = longint'(t.tick); ap = t.applied;
      if (t.cmd) begin
        wipe();
        pending.push_back(r);
        return;
      end
      rate = 0; iterm = 0; valid = 0;
      bound = sat_q(lim_pose + 64'sd327680);
      pose = lim(pose + rnd_div(ap * 65536 * tk, 1000), -bound, bound);
      if (t.frame) begin
        if (!seen) begin
          vel_f = s;
          acc_f = 0;
        end else begin
          fdt = t.ftime - last_ft;
          fdt_l = longint'(fdt);
          if (fdt >= 32'd10 && fdt <= 32'd100) begin
            raw = lim(rnd_div((s - prev_spd) * 1000, fdt_l), -64'sd131072000, 64'sd131072000);
            acc_f = acc_f + rnd_div(64'sd16384 * (raw - acc_f), 65536);
          end else begin
            acc_f = 0;
          end
          vel_f = vel_f + rnd_div(64'sd16384 * (s - vel_f), 65536);
        end
        last_pos = p; prev_spd = s; last_ft = t.ftime; seen = 1;
      end
      age = t.now - last_ft;
      age_l = longint'(age);
      if (!seen || age > 32'd100) begin
        integ = 0;
      end else begin
        pred = sat_q(last_pos + rnd_div(vel_f * age_l, 1000));
        acc = integ + rnd_div(pred * tk, 1000);
        leak = lim(65536 - rnd_div(64'sd65536 * tk, 1000), 0, 65536);
        acc = rnd_div(acc * leak, 65536);
        integ = lim(acc, -lim_int, lim_int);
        sum = rnd_div(g_pos * pred, 65536) + rnd_div(g_vel * vel_f, 65536)
            + rnd_div(g_int * integ, 65536) - rnd_div(g_pose * pose, 65536)
            + rnd_div(g_acc * acc_f, 65536);
        rate = lim(sum, -lim_rate, lim_rate);
        if ((pose >= lim_pose && rate > 0) || (pose <= -lim_pose && rate < 0)) rate = 0;
        iterm = sat_q(rnd_div(g_int * integ, 65536));
        valid = 1;
      end
      aterm_l = sat_q(rnd_div(g_acc * acc_f, 65536));
      r.rate = rate[31:0];
      r.valid = valid;
      r.iterm = iterm[31:0];
      r.accel = acc_f[31:0];
      r.aterm = aterm_l[31:0];
      r.pose = pose[31:0];
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(ctrl_beat_t got);
      ctrl_beat_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result beat %h", got));
        return;
      end
      exp_r = pending.pop_front();
      if (got.rate !== exp_r.rate)
        report($sformatf("rate_out %h, want %h", got.rate, exp_r.rate));
      if (got.valid !== exp_r.valid)
        report($sformatf("valid_res %b, want %b", got.valid, exp_r.valid));
      if (got.iterm !== exp_r.iterm)
        report($sformatf("integral_term %h, want %h", got.iterm, exp_r.iterm));
      if (got.accel !== exp_r.accel)
        report($sformatf("accel_estimate %h, want %h", got.accel, exp_r.accel));
      if (got.aterm !== exp_r.aterm)
        report($sformatf("accel_term %h, want %h", got.aterm, exp_r.aterm));
      if (got.pose !== exp_r.pose)
        report($sformatf("pose_out %h, want %h", got.pose, exp_r.pose));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [167:0] m_axis_tdata;

  mzsf_scoreboard sb = new();
  longint cycles = 0;
  int burst_left = 0;
  logic [31:0] sim_now = 32'd1000;
  int since_frame = 0;

  always #6 clk = ~clk;

  moving_zero_state_feedback i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: the stall pattern is redrawn whenever its mode counter runs out
  int stall_mode = 0;
  int stall_left = 0;
  int mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(200, 3000);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 99) < 3) stall_left = $urandom_range(10, 400);
        end
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(ctrl_beat_t'(m_axis_tdata));
  end

  // Send one tick, with bursts and gaps in between
  task send_tick(tick_beat_t t);
    if (burst_left == 0) begin
      @(negedge clk);
      s_axis_tvalid = 0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2500) : $urandom_range(1, 30))
        @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end else begin
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = t;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(t);
    burst_left--;
  endtask

  task wait_drained();
    @(negedge clk);
    s_axis_tvalid = 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task write_cfg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task load_all(logic [31:0] gp, logic [31:0] gv, logic [31:0] gi, logic [31:0] gpo,
                logic [31:0] ga, logic [31:0] rl, logic [31:0] pl, logic [31:0] il);
    wait_drained();
    write_cfg(REG_GAIN_POSITION, gp);
    write_cfg(REG_GAIN_VELOCITY, gv);
    write_cfg(REG_GAIN_INTEGRAL, gi);
    write_cfg(REG_GAIN_POSE, gpo);
    write_cfg(REG_GAIN_ACCEL, ga);
    write_cfg(REG_RATE_LIMIT, rl);
    write_cfg(REG_POSE_LIMIT, pl);
    write_cfg(REG_INTEGRAL_LIMIT, il);
  endtask

  function tick_beat_t mk(bit c, bit f, logic [31:0] p, logic [31:0] s, logic [31:0] ft,
                          logic [31:0] nw, logic [9:0] tk, logic [16:0] ap);
    tick_beat_t t;
    t = '0;
    t.cmd = c; t.frame = f; t.pos = p; t.spd = s; t.ftime = ft; t.now = nw;
    t.tick = tk; t.applied = ap;
    return t;
  endfunction

  // Mostly coherent timelines with random content, some noise and clears
  function tick_beat_t rand_tick();
    tick_beat_t t;
    int kind;
    t = '0;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t.pad = '0;
      return t;
    end
    t.tick = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(1, 20));
    if ($urandom_range(0, 30) == 0) sim_now = sim_now + $urandom_range(100, 3000);
    sim_now = sim_now + t.tick;
    t.now = sim_now;
    since_frame += t.tick;
    t.frame = (since_frame >= 8 && $urandom_range(0, 2) != 0) || $urandom_range(0, 9) == 0;
    if (t.frame) since_frame = 0;
    t.ftime = sim_now - $urandom_range(0, 4);
    if (kind < 11) t.ftime = $urandom;
    if (kind < 16) begin
      t.pos = $urandom; t.spd = $urandom;
    end else begin
      t.pos = 32'($signed($urandom_range(0, 2 * 300 * 65536)) - 300 * 65536);
      t.spd = 32'($signed($urandom_range(0, 2 * 800 * 65536)) - 800 * 65536);
    end
    t.applied = ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                             : 17'($signed($urandom_range(0, 6000)) - 3000);
    t.cmd = ($urandom_range(0, 49) == 0);
    return t;
  endfunction

  function logic [31:0] rand_gain();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 4 * 65536);
      2: return $urandom_range(0, 8192);
      default: return 32'h0;
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // registers at reset values
    for (int i = 0; i < 8; i++) send_tick(rand_tick());

    load_all(32'h0002_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_1999,
             32'hFFFF_FD71, 32'h1388_0000, 32'h07D0_0000, 32'h03E8_0000);

    // directed: clears, first frame, gaps, stale frames, wraps and extremes
    send_tick(mk(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, '1, '1));
    send_tick(mk(0, 0, 0, 0, 0, 32'd50, 10'd1, 17'd0));
    send_tick(mk(0, 1, 32'h0010_0000, 32'h0020_0000, 32'd0, 32'd3, 10'd1, 17'd100));
    send_tick(mk(0, 1, 32'h0011_0000, 32'h0030_0000, 32'd5, 32'd6, 10'd1, 17'd100));
    send_tick(mk(0, 1, 32'h0012_0000, 32'h0050_0000, 32'd55, 32'd56, 10'd5, 17'h1FF00));
    send_tick(mk(0, 1, 32'h0012_0000, 32'h8000_0000, 32'd65, 32'd66, 10'd10, 17'h0FFFF));
    send_tick(mk(0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd165, 32'd170, 10'd10, 17'h10000));
    send_tick(mk(0, 0, 0, 0, 0, 32'd265, 10'd1000, 17'h0FFFF));
    send_tick(mk(0, 0, 0, 0, 0, 32'd266, 10'd0, 17'h10000));
    send_tick(mk(0, 1, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFF0, 32'hFFFF_FFF5, 10'd1023,
                 17'h00001));
    send_tick(mk(0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0010, 32'h0000_0020, 10'd3,
                 17'h1FFFF));
    send_tick(mk(0, 0, 0, 0, 0, 32'h0000_0084, 10'd2, 17'd0));
    send_tick(mk(0, 0, 0, 0, 0, 32'h0000_0085, 10'd2, 17'd0));
    send_tick(mk(1, 0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 1, 32'h0001_0000, 32'hFFF0_0000, 32'd0, 32'd0, 10'd1, 17'd0));
    send_tick(mk(0, 1, 32'h0001_0000, 32'h0010_0000, 32'd10, 32'd10, 10'd10, 17'd0));
    send_tick(mk(0, 1, 32'hFFFF_0000, 32'h0010_0000, 32'd110, 32'd110, 10'd100, 17'd0));
    send_tick(mk(0, 1, 32'hFFFF_0000, 32'h0000_0000, 32'd210, 32'd211, 10'd1, 17'd0));
    send_tick(mk(0, 1, 32'hFFFF_0000, 32'h0000_0000, 32'd221, 32'd221, 10'd1, 17'd0));

    // hold off until every result of the directed part is back
    wait_drained();

    // random phases over several register settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: load_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        1: load_all(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        2: load_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(), $urandom,
                    $urandom, $urandom, $urandom);
        3: load_all(32'h0001_0000, 32'h0000_4000, 32'h0000_2000, 32'h0000_0800,
                    32'($signed($urandom_range(0, 2000)) - 1000), 32'h0010_0000,
                    32'($urandom_range(0, 32'h0100_0000)), 32'h0100_0000);
        default: load_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                          rand_gain() | ($urandom_range(0, 1) << 31),
                          $urandom_range(0, 32'h0800_0000), $urandom_range(0, 32'h0100_0000),
                          $urandom_range(0, 32'h0800_0000));
      endcase
      for (int i = 0; i < 113; i++) send_tick(rand_tick());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mzsf_pkg.sv
rtl/core/mzsf_muldiv.sv
rtl/core/moving_zero_state_feedback.sv
tb/tb_top.sv
